>>> sv/pre_pkg.sv
// shared types, command codes, datapath operation codes and bresenham helpers
package pre_pkg;

  typedef logic signed [13:0] coord_t;
  typedef logic signed [15:0] err_t;
  typedef logic signed [23:0] cerr_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] bx;
    logic signed [11:0] by;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [10:0]        radius;
    logic [7:0]         paint;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       read_inside;
  } res_t;

  localparam logic [2:0] CMD_PIXEL   = 3'd0;
  localparam logic [2:0] CMD_LINE    = 3'd1;
  localparam logic [2:0] CMD_OUTLINE = 3'd2;
  localparam logic [2:0] CMD_BOX     = 3'd3;
  localparam logic [2:0] CMD_CIRCLE  = 3'd4;
  localparam logic [2:0] CMD_TRI     = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_PIX       = 5'd2;
  localparam logic [4:0] OP_LINE_INIT = 5'd3;
  localparam logic [4:0] OP_LINE      = 5'd4;
  localparam logic [4:0] OP_OL_SET    = 5'd5;
  localparam logic [4:0] OP_SPAN      = 5'd6;
  localparam logic [4:0] OP_BOX_INIT  = 5'd7;
  localparam logic [4:0] OP_BOX_ROW   = 5'd8;
  localparam logic [4:0] OP_ROW_INC   = 5'd9;
  localparam logic [4:0] OP_CIR_INIT  = 5'd10;
  localparam logic [4:0] OP_CIR       = 5'd11;
  localparam logic [4:0] OP_TRI_INIT  = 5'd12;
  localparam logic [4:0] OP_TRI_A     = 5'd13;
  localparam logic [4:0] OP_TRI_B     = 5'd14;
  localparam logic [4:0] OP_TRI_SET   = 5'd15;
  localparam logic [4:0] OP_RD        = 5'd16;
  localparam logic [4:0] OP_RESULT    = 5'd17;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] pass;
    logic       is_read;
  } ctl_t;

  typedef struct packed {
    logic a_end;
    logic span_last;
    logic span_void;
    logic box_void;
    logic row_last;
    logic cir_last;
    logic tri_flat;
    logic tri_a_moved;
    logic b_moved;
    logic b_bottom;
  } stat_t;

  // sx, sy set means the walker steps towards smaller coordinates
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t tx;
    coord_t ty;
    coord_t dx;
    coord_t dy;
    logic   sx;
    logic   sy;
    err_t   err;
  } walker_t;

  function automatic walker_t wk_init(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    walker_t w;
    coord_t  adx;
    coord_t  ady;
    coord_t  ndy;
    adx = x1 - x0;
    if (adx < 0) adx = -adx;
    ady = y1 - y0;
    if (ady < 0) ady = -ady;
    ndy = -ady;
    w.x = x0;
    w.y = y0;
    w.tx = x1;
    w.ty = y1;
    w.dx = adx;
    w.dy = ndy;
    w.sx = !(x0 < x1);
    w.sy = !(y0 < y1);
    w.err = err_t'(adx) + err_t'(ndy);
    return w;
  endfunction

  function automatic logic wk_moves(walker_t w);
    logic signed [16:0] e2;
    logic signed [16:0] dx17;
    e2 = {w.err, 1'b0};
    dx17 = 17'(w.dx);
    return e2 <= dx17;
  endfunction

  function automatic walker_t wk_step(walker_t w);
    walker_t n;
    logic signed [16:0] e2;
    logic signed [16:0] dx17;
    logic signed [16:0] dy17;
    n = w;
    e2 = {w.err, 1'b0};
    dx17 = 17'(w.dx);
    dy17 = 17'(w.dy);
    if (e2 >= dy17) begin
      n.err = n.err + err_t'(w.dy);
      n.x = w.sx ? w.x - 14'sd1 : w.x + 14'sd1;
    end
    if (e2 <= dx17) begin
      n.err = n.err + err_t'(w.dx);
      n.y = w.sy ? w.y - 14'sd1 : w.y + 14'sd1;
    end
    return n;
  endfunction

endpackage

>>> sv/pre_ctrl.sv
// command sequencer: walks each draw command through its datapath operations
module pre_ctrl import pre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [2:0] command,
  output logic       res_valid,
  input  logic       res_ready,
  input  stat_t      st,
  output ctl_t       ctl
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_PIX       = 5'd1;
  localparam logic [4:0] S_LINE_INIT = 5'd2;
  localparam logic [4:0] S_LINE      = 5'd3;
  localparam logic [4:0] S_OL_SET    = 5'd4;
  localparam logic [4:0] S_OL_RUN    = 5'd5;
  localparam logic [4:0] S_BOX_INIT  = 5'd6;
  localparam logic [4:0] S_BOX_ROW   = 5'd7;
  localparam logic [4:0] S_BOX_RUN   = 5'd8;
  localparam logic [4:0] S_BOX_NEXT  = 5'd9;
  localparam logic [4:0] S_CIR_INIT  = 5'd10;
  localparam logic [4:0] S_CIR       = 5'd11;
  localparam logic [4:0] S_TRI_INIT  = 5'd12;
  localparam logic [4:0] S_TRI_A     = 5'd13;
  localparam logic [4:0] S_TRI_B     = 5'd14;
  localparam logic [4:0] S_TRI_SET   = 5'd15;
  localparam logic [4:0] S_TRI_RUN   = 5'd16;
  localparam logic [4:0] S_TRI_CHK   = 5'd17;
  localparam logic [4:0] S_RD        = 5'd18;
  localparam logic [4:0] S_RW1       = 5'd19;
  localparam logic [4:0] S_RW2       = 5'd20;
  localparam logic [4:0] S_FIN       = 5'd21;

  logic [4:0] state, state_next;
  logic [1:0] pass, pass_next;
  logic       is_read, is_read_next;
  logic       res_valid_next;

  always_comb begin
    state_next = state;
    pass_next = pass;
    is_read_next = is_read;
    res_valid_next = res_valid && !res_ready;
    cmd_ready = 1'b0;
    ctl.op = OP_NONE;
    ctl.pass = pass;
    ctl.is_read = is_read;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.op = OP_LOAD;
          is_read_next = (command == CMD_READ);
          pass_next = 2'd0;
          case (command)
            CMD_PIXEL:   state_next = S_PIX;
            CMD_LINE:    state_next = S_LINE_INIT;
            CMD_OUTLINE: state_next = S_OL_SET;
            CMD_BOX:     state_next = S_BOX_INIT;
            CMD_CIRCLE:  state_next = S_CIR_INIT;
            CMD_TRI:     state_next = S_TRI_INIT;
            CMD_READ:    state_next = S_RD;
            default:     state_next = S_FIN;
          endcase
        end
      end
      S_PIX: begin
        ctl.op = OP_PIX;
        state_next = S_FIN;
      end
      S_LINE_INIT: begin
        ctl.op = OP_LINE_INIT;
        state_next = S_LINE;
      end
      S_LINE: begin
        ctl.op = OP_LINE;
        if (st.a_end) state_next = S_FIN;
      end
      S_OL_SET: begin
        ctl.op = OP_OL_SET;
        state_next = S_OL_RUN;
      end
      S_OL_RUN: begin
        ctl.op = OP_SPAN;
        if (st.span_last) begin
          if (pass == 2'd3) begin
            state_next = S_FIN;
          end else begin
            pass_next = pass + 2'd1;
            state_next = S_OL_SET;
          end
        end
      end
      S_BOX_INIT: begin
        ctl.op = OP_BOX_INIT;
        state_next = st.box_void ? S_FIN : S_BOX_ROW;
      end
      S_BOX_ROW: begin
        ctl.op = OP_BOX_ROW;
        // an empty column range stays empty on every row
        state_next = st.span_void ? S_FIN : S_BOX_RUN;
      end
      S_BOX_RUN: begin
        ctl.op = OP_SPAN;
        if (st.span_last) state_next = st.row_last ? S_FIN : S_BOX_NEXT;
      end
      S_BOX_NEXT: begin
        ctl.op = OP_ROW_INC;
        state_next = S_BOX_ROW;
      end
      S_CIR_INIT: begin
        ctl.op = OP_CIR_INIT;
        state_next = S_CIR;
      end
      S_CIR: begin
        ctl.op = OP_CIR;
        if (st.cir_last) state_next = S_FIN;
      end
      S_TRI_INIT: begin
        ctl.op = OP_TRI_INIT;
        state_next = st.tri_flat ? S_LINE : S_TRI_A;
      end
      S_TRI_A: begin
        ctl.op = OP_TRI_A;
        if (st.tri_a_moved) state_next = S_TRI_B;
      end
      S_TRI_B: begin
        ctl.op = OP_TRI_B;
        if (st.b_moved) state_next = S_TRI_SET;
      end
      S_TRI_SET: begin
        ctl.op = OP_TRI_SET;
        state_next = st.span_void ? S_TRI_CHK : S_TRI_RUN;
      end
      S_TRI_RUN: begin
        ctl.op = OP_SPAN;
        if (st.span_last) state_next = S_TRI_CHK;
      end
      S_TRI_CHK: begin
        state_next = st.b_bottom ? S_FIN : S_TRI_A;
      end
      S_RD: begin
        ctl.op = OP_RD;
        state_next = S_RW1;
      end
      S_RW1: state_next = S_RW2;
      S_RW2: state_next = S_FIN;
      S_FIN: begin
        if (!res_valid || res_ready) begin
          ctl.op = OP_RESULT;
          res_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass <= 2'd0;
      is_read <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass <= pass_next;
      is_read <= is_read_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

>>> sv/pre_dp.sv
// rasterizer datapath: walkers, span and circle steppers, pixel pipeline and canvas
module pre_dp import pre_pkg::*; #(
  parameter int CANVAS_WIDTH  = 512,
  parameter int CANVAS_HEIGHT = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  ctl_t  ctl,
  output stat_t st,
  output res_t  res
);

  localparam int     DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int     XW    = $clog2(CANVAS_WIDTH);
  localparam int     YW    = $clog2(CANVAS_HEIGHT);
  localparam int     AW    = $clog2(DEPTH);
  localparam coord_t XMAX  = coord_t'(CANVAS_WIDTH - 1);
  localparam coord_t YMAX  = coord_t'(CANVAS_HEIGHT - 1);

  coord_t      ax, ay, bx, by, cx, cy;
  logic [10:0] radius;
  logic [7:0]  paint;
  walker_t     wa, wb;
  logic        lower;
  coord_t      p1x, p1y, p2x, p2y;
  coord_t      si, se, sf;
  logic        svert;
  coord_t      yr, ye;
  coord_t      ccx, ccy;
  cerr_t       cerr;
  logic [1:0]  cq;

  // combinational helpers
  walker_t wa_step, wb_step;
  walker_t tri_a, tri_b, flat_a;
  coord_t  sx0, sy0, sx1, sy1, sx2, sy2;
  logic    flat;
  coord_t  ol_i, ol_e, ol_f;
  coord_t  box_yr, box_ye, row_i, row_e;
  coord_t  tri_i, tri_e;
  logic    tri_reinit;
  coord_t  nx, ny;
  cerr_t   ne;

  // pixel request
  logic   pr_en, pr_rd;
  coord_t pr_x, pr_y;

  assign wa_step = wk_step(wa);
  assign wb_step = wk_step(wb);
  assign flat = (ay == by) && (ay == cy);
  assign tri_reinit = !lower && (wa.x == p1x) && (wa.y == p1y);

  always_comb begin
    coord_t tx, ty, mn, mx;
    tx = '0;
    ty = '0;
    sx0 = ax; sy0 = ay; sx1 = bx; sy1 = by; sx2 = cx; sy2 = cy;
    // stable three-way swap network on y
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy0 > sy2) begin
      tx = sx0; ty = sy0; sx0 = sx2; sy0 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    tri_a = wk_init(sx0, sy0, sx1, sy1);
    tri_b = wk_init(sx0, sy0, sx2, sy2);
    mn = (ax < bx) ? ax : bx;
    mn = (cx < mn) ? cx : mn;
    mx = (ax > bx) ? ax : bx;
    mx = (cx > mx) ? cx : mx;
    flat_a = wk_init(mn, ay, mx, ay);
  end

  // outline passes: two rows, then two columns
  always_comb begin
    if (ctl.pass[1]) begin
      ol_i = (ay < by) ? ay : by;
      ol_e = (ay < by) ? by : ay;
      ol_f = ctl.pass[0] ? bx : ax;
    end else begin
      ol_i = (ax < bx) ? ax : bx;
      ol_e = (ax < bx) ? bx : ax;
      ol_f = ctl.pass[0] ? by : ay;
    end
  end

  always_comb begin
    coord_t lo, hi, t;
    t = (ay < by) ? ay : by;
    box_yr = (t < 0) ? 14'sd0 : t;
    t = (ay < by) ? by : ay;
    box_ye = (t > YMAX) ? YMAX : t;
    t = (ax < bx) ? ax : bx;
    row_i = (t < 0) ? 14'sd0 : t;
    t = (ax < bx) ? bx : ax;
    row_e = (t > XMAX) ? XMAX : t;
    lo = (wa.x < wb.x) ? wa.x : wb.x;
    hi = ((wa.x < wb.x) ? wb.x : wa.x) - 14'sd1;
    tri_i = (lo < 0) ? 14'sd0 : lo;
    tri_e = (hi > XMAX) ? XMAX : hi;
  end

  // midpoint circle step
  always_comb begin
    nx = ccx;
    ny = ccy;
    ne = cerr;
    if (cerr > cerr_t'(ccx)) begin
      nx = ccx + 14'sd1;
      ne = ne + (cerr_t'(nx) <<< 1) + 24'sd1;
    end
    if (cerr <= cerr_t'(ccy)) begin
      ny = ccy + 14'sd1;
      ne = ne + (cerr_t'(ny) <<< 1) + 24'sd1;
    end
  end

  always_comb begin
    st.a_end = (wa.x == wa.tx) && (wa.y == wa.ty);
    st.span_last = (si == se);
    st.box_void = box_yr > box_ye;
    st.row_last = (yr == ye);
    st.cir_last = (cq == 2'd3) && !(nx < 0);
    st.tri_flat = flat;
    st.tri_a_moved = !tri_reinit && wk_moves(wa);
    st.b_moved = wk_moves(wb);
    st.b_bottom = (wb.y == p2y);
    if (ctl.op == OP_TRI_SET) begin
      st.span_void = (wb.y < 0) || (wb.y > YMAX) || (tri_i > tri_e);
    end else begin
      st.span_void = row_i > row_e;
    end
  end

  always_comb begin
    pr_en = 1'b0;
    pr_rd = 1'b0;
    pr_x = ax;
    pr_y = ay;
    case (ctl.op)
      OP_PIX: pr_en = 1'b1;
      OP_RD:  pr_rd = 1'b1;
      OP_LINE: begin
        pr_en = 1'b1;
        pr_x = wa.x;
        pr_y = wa.y;
      end
      OP_SPAN: begin
        pr_en = 1'b1;
        pr_x = svert ? sf : si;
        pr_y = svert ? si : sf;
      end
      OP_CIR: begin
        pr_en = 1'b1;
        case (cq)
          2'd0: begin pr_x = ax - ccx; pr_y = ay + ccy; end
          2'd1: begin pr_x = ax - ccy; pr_y = ay - ccx; end
          2'd2: begin pr_x = ax + ccx; pr_y = ay - ccy; end
          default: begin pr_x = ax + ccy; pr_y = ay + ccx; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        ax <= coord_t'(cmd.ax);
        ay <= coord_t'(cmd.ay);
        bx <= coord_t'(cmd.bx);
        by <= coord_t'(cmd.by);
        cx <= coord_t'(cmd.cx);
        cy <= coord_t'(cmd.cy);
        radius <= cmd.radius;
        paint <= cmd.paint;
      end
      OP_LINE_INIT: wa <= wk_init(ax, ay, bx, by);
      OP_LINE: if (!st.a_end) wa <= wa_step;
      OP_OL_SET: begin
        si <= ol_i;
        se <= ol_e;
        sf <= ol_f;
        svert <= ctl.pass[1];
      end
      OP_SPAN: si <= si + 14'sd1;
      OP_BOX_INIT: begin
        yr <= box_yr;
        ye <= box_ye;
      end
      OP_BOX_ROW: begin
        si <= row_i;
        se <= row_e;
        sf <= yr;
        svert <= 1'b0;
      end
      OP_ROW_INC: yr <= yr + 14'sd1;
      OP_CIR_INIT: begin
        ccx <= 14'sd0 - coord_t'({3'b000, radius});
        ccy <= 14'sd0;
        cerr <= 24'sd2 - (cerr_t'({13'b0, radius}) <<< 1);
        cq <= 2'd0;
      end
      OP_CIR: begin
        cq <= cq + 2'd1;
        if (cq == 2'd3) begin
          ccx <= nx;
          ccy <= ny;
          cerr <= ne;
        end
      end
      OP_TRI_INIT: begin
        if (flat) begin
          wa <= flat_a;
        end else begin
          wa <= tri_a;
          wb <= tri_b;
        end
        lower <= 1'b0;
        p1x <= sx1;
        p1y <= sy1;
        p2x <= sx2;
        p2y <= sy2;
      end
      OP_TRI_A: begin
        if (tri_reinit) begin
          wa <= wk_init(p1x, p1y, p2x, p2y);
          lower <= 1'b1;
        end else begin
          wa <= wa_step;
        end
      end
      OP_TRI_B: wb <= wb_step;
      OP_TRI_SET: begin
        si <= tri_i;
        se <= tri_e;
        sf <= wb.y;
        svert <= 1'b0;
      end
      default: ;
    endcase
  end

  // pixel pipeline: clip, address, canvas access
  logic          s1_en, s1_rd, s1_in;
  logic [XW-1:0] s1_x;
  logic [YW-1:0] s1_y;
  logic [7:0]    s1_paint;
  logic          s2_wen, s2_rd, s2_in;
  logic [AW-1:0] s2_addr;
  logic [7:0]    s2_paint;
  logic [7:0]    rdata;
  logic          rd_in;
  logic [7:0]    canvas [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_en <= 1'b0;
      s1_rd <= 1'b0;
      s2_wen <= 1'b0;
      s2_rd <= 1'b0;
    end else begin
      s1_en <= pr_en;
      s1_rd <= pr_rd;
      s2_wen <= s1_en && s1_in;
      s2_rd <= s1_rd;
    end
  end

  always_ff @(posedge clk) begin
    s1_in <= (pr_x >= 0) && (pr_x <= XMAX) && (pr_y >= 0) && (pr_y <= YMAX);
    s1_x <= pr_x[XW-1:0];
    s1_y <= pr_y[YW-1:0];
    s1_paint <= paint;
    s2_in <= s1_in;
    s2_addr <= AW'(s1_y) * AW'(CANVAS_WIDTH) + AW'(s1_x);
    s2_paint <= s1_paint;
  end

  always_ff @(posedge clk) begin
    if (s2_wen) canvas[s2_addr] <= s2_paint;
    if (s2_rd && s2_in) rdata <= canvas[s2_addr];
    if (s2_rd) rd_in <= s2_in;
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_RESULT) begin
      res.read_inside <= ctl.is_read && rd_in;
      res.read_value <= (ctl.is_read && rd_in) ? rdata : 8'd0;
    end
  end

endmodule

>>> sv/primitive_raster_engine.sv
// top level of the 2-d primitive rasterizer with its canvas memory
//
//   channel  valid      ready      payload  direction
//   draw     cmd_valid  cmd_ready  cmd      in
//   result   res_valid  res_ready  res      out
//
// one command at a time; at most one pixel issued per cycle by the sequencer
// a read waits in S_RW1 and S_RW2 for its data; rectangles add the S_BOX_ROW and
// S_BOX_NEXT states per row, triangles add S_TRI_A and S_TRI_B per edge step and
// S_TRI_SET and S_TRI_CHK per row
// writes pass through the registers of the pixel pipeline, and reads see them
// reset clears control only; canvas contents are undefined until written
// a new command is taken while the previous result waits in the output register
module primitive_raster_engine import pre_pkg::*; #(
  parameter int CANVAS_WIDTH  = 512,
  parameter int CANVAS_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  ctl_t  ctl;
  stat_t st;

  pre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (cmd.command),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .st        (st),
    .ctl       (ctl)
  );

  pre_dp #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ctl (ctl),
    .st  (st),
    .res (res)
  );

endmodule

>>> tb/primitive_raster_engine_tb.sv
// testbench for the primitive rasterizer: software canvas predictor plus random draw traffic
module primitive_raster_engine_tb;
  import pre_pkg::*;

  localparam int CANVAS_WIDTH  = 512;
  localparam int CANVAS_HEIGHT = 256;
  localparam int CANVAS_SIZE   = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam logic [2:0] CMD_SPARE = 3'd7;

  typedef struct {
    int x, y, dx, dy, sx, sy, err;
  } stepper_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;

  logic [7:0] shadow_canvas [CANVAS_SIZE];
  bit         painted [CANVAS_SIZE];
  int         painted_addrs [$];
  res_t       expected_readback [$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         errors;

  primitive_raster_engine #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------- canvas predictor ----------------
  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < CANVAS_WIDTH && y >= 0 && y < CANVAS_HEIGHT;
  endfunction

  function automatic void put_pixel(int x, int y, logic [7:0] c);
    int a;
    if (on_canvas(x, y)) begin
      a = y * CANVAS_WIDTH + x;
      shadow_canvas[a] = c;
      if (!painted[a]) begin
        painted[a] = 1'b1;
        painted_addrs.push_back(a);
      end
    end
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic void fill_row(int xa, int xb, int y, logic [7:0] c);
    if (y < 0 || y >= CANVAS_HEIGHT) return;
    for (int x = imax(xa, 0); x <= imin(xb, CANVAS_WIDTH - 1); x++) put_pixel(x, y, c);
  endfunction

  function automatic stepper_t stepper_start(int x0, int y0, int x1, int y1);
    stepper_t s;
    s.x = x0;
    s.y = y0;
    s.dx = x1 > x0 ? x1 - x0 : x0 - x1;
    s.dy = y1 > y0 ? y0 - y1 : y1 - y0;
    s.sx = x0 < x1 ? 1 : -1;
    s.sy = y0 < y1 ? 1 : -1;
    s.err = s.dx + s.dy;
    return s;
  endfunction

  // one bresenham step; true when the row changed
  function automatic bit stepper_advance(inout stepper_t s);
    int e2;
    e2 = 2 * s.err;
    if (e2 >= s.dy) begin
      s.err += s.dy;
      s.x += s.sx;
    end
    if (e2 <= s.dx) begin
      s.err += s.dx;
      s.y += s.sy;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic [7:0] c);
    stepper_t s;
    bit moved;
    s = stepper_start(x0, y0, x1, y1);
    forever begin
      put_pixel(s.x, s.y, c);
      if (s.x == x1 && s.y == y1) break;
      moved = stepper_advance(s);
    end
  endfunction

  function automatic void trace_circle(int xm, int ym, int r, logic [7:0] c);
    int x, y, err, prev;
    x = -r;
    y = 0;
    err = 2 - 2 * r;
    do begin
      put_pixel(xm - x, ym + y, c);
      put_pixel(xm - y, ym - x, c);
      put_pixel(xm + x, ym - y, c);
      put_pixel(xm + y, ym + x, c);
      prev = err;
      if (prev > x) begin
        x++;
        err += x * 2 + 1;
      end
      if (prev <= y) begin
        y++;
        err += y * 2 + 1;
      end
    end while (x < 0);
  endfunction

  function automatic void trace_outline(int x0, int y0, int x1, int y1, logic [7:0] c);
    for (int i = imin(x0, x1); i <= imax(x0, x1); i++) begin
      put_pixel(i, y0, c);
      put_pixel(i, y1, c);
    end
    for (int i = imin(y0, y1); i <= imax(y0, y1); i++) begin
      put_pixel(x0, i, c);
      put_pixel(x1, i, c);
    end
  endfunction

  function automatic void fill_box(int x0, int y0, int x1, int y1, logic [7:0] c);
    for (int y = imax(imin(y0, y1), 0); y <= imin(imax(y0, y1), CANVAS_HEIGHT - 1); y++)
      fill_row(imin(x0, x1), imax(x0, x1), y, c);
  endfunction

  function automatic void fill_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                                        logic [7:0] c);
    int px[3], py[3], t;
    stepper_t ea, eb;
    bit lower, moved;
    px = '{x0, x1, x2};
    py = '{y0, y1, y2};
    lower = 1'b0;
    if (y0 == y1 && y0 == y2) begin
      trace_line(imin(x0, imin(x1, x2)), y0, imax(x0, imax(x1, x2)), y0, c);
      return;
    end
    // stable sort by y
    if (py[0] > py[1]) begin
      t = px[0]; px[0] = px[1]; px[1] = t;
      t = py[0]; py[0] = py[1]; py[1] = t;
    end
    if (py[0] > py[2]) begin
      t = px[0]; px[0] = px[2]; px[2] = t;
      t = py[0]; py[0] = py[2]; py[2] = t;
    end
    if (py[1] > py[2]) begin
      t = px[1]; px[1] = px[2]; px[2] = t;
      t = py[1]; py[1] = py[2]; py[2] = t;
    end
    ea = stepper_start(px[0], py[0], px[1], py[1]);
    eb = stepper_start(px[0], py[0], px[2], py[2]);
    do begin
      forever begin
        if (!lower && ea.x == px[1] && ea.y == py[1]) begin
          ea = stepper_start(px[1], py[1], px[2], py[2]);
          lower = 1'b1;
        end
        if (stepper_advance(ea)) break;
      end
      do moved = stepper_advance(eb); while (!moved);
      fill_row(imin(ea.x, eb.x), imax(ea.x, eb.x) - 1, eb.y, c);
    end while (eb.y != py[2]);
  endfunction

  function automatic res_t raster_predict(cmd_t k);
    res_t r;
    r = '0;
    case (k.command)
      CMD_PIXEL:   put_pixel(k.ax, k.ay, k.paint);
      CMD_LINE:    trace_line(k.ax, k.ay, k.bx, k.by, k.paint);
      CMD_OUTLINE: trace_outline(k.ax, k.ay, k.bx, k.by, k.paint);
      CMD_BOX:     fill_box(k.ax, k.ay, k.bx, k.by, k.paint);
      CMD_CIRCLE:  trace_circle(k.ax, k.ay, int'(k.radius), k.paint);
      CMD_TRI:     fill_triangle(k.ax, k.ay, k.bx, k.by, k.cx, k.cy, k.paint);
      CMD_READ: begin
        if (on_canvas(k.ax, k.ay)) begin
          r.read_value = shadow_canvas[int'(k.ay) * CANVAS_WIDTH + int'(k.ax)];
          r.read_inside = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- drivers and checker ----------------
  task automatic send_command(cmd_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= k;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    expected_readback.push_back(raster_predict(k));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_readback.size() == 0) begin
        $display("%0t: unexpected result value=%0d inside=%0b", $time,
                 res.read_value, res.read_inside);
        errors++;
      end else begin
        want = expected_readback.pop_front();
        if (res.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time,
                   want.read_value, res.read_value);
          errors++;
        end
        if (res.read_inside !== want.read_inside) begin
          $display("%0t: read_inside expected %0b actual %0b", $time,
                   want.read_inside, res.read_inside);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic cmd_t make_cmd(logic [2:0] op, int ax, int ay, int bx, int by,
                                    int cx, int cy, int r, int c);
    cmd_t k;
    k.command = op;
    k.ax = 12'(ax);
    k.ay = 12'(ay);
    k.bx = 12'(bx);
    k.by = 12'(by);
    k.cx = 12'(cx);
    k.cy = 12'(cy);
    k.radius = 11'(r);
    k.paint = 8'(c);
    return k;
  endfunction

  function automatic int clamp12(int v);
    return imax(-2048, imin(2047, v));
  endfunction

  function automatic int rand_signed(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // base points mostly around the canvas, now and then anywhere in the field range
  function automatic int base_coord(int span_limit);
    if ($urandom_range(19) == 0) return rand_signed(-2048, 2047);
    return rand_signed(-30, span_limit + 30);
  endfunction

  function automatic int nearby(int v);
    int reach;
    reach = ($urandom_range(24) == 0) ? 200 : 16;
    return clamp12(v + rand_signed(-reach, reach));
  endfunction

  function automatic cmd_t random_read();
    int a;
    if (painted_addrs.size() > 0 && $urandom_range(9) < 7) begin
      a = painted_addrs[$urandom_range(painted_addrs.size() - 1)];
      return make_cmd(CMD_READ, a % CANVAS_WIDTH, a / CANVAS_WIDTH, rand_signed(-2048, 2047),
                      rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                      rand_signed(-2048, 2047), $urandom_range(2047), $urandom_range(255));
    end
    // off-canvas read: either coordinate out of range
    if ($urandom_range(1))
      return make_cmd(CMD_READ, $urandom_range(1) ? rand_signed(-2048, -1)
                      : rand_signed(CANVAS_WIDTH, 2047), rand_signed(-2048, 2047),
                      0, 0, 0, 0, 0, $urandom_range(255));
    return make_cmd(CMD_READ, rand_signed(-2048, 2047), $urandom_range(1) ?
                    rand_signed(-2048, -1) : rand_signed(CANVAS_HEIGHT, 2047),
                    0, 0, 0, 0, 0, $urandom_range(255));
  endfunction

  function automatic cmd_t random_command();
    int ax, ay, sel, r;
    ax = base_coord(CANVAS_WIDTH);
    ay = base_coord(CANVAS_HEIGHT);
    sel = $urandom_range(99);
    r = ($urandom_range(49) == 0) ? $urandom_range(2047) : $urandom_range(20);
    if (sel < 35) return random_read();
    if (sel < 45) return make_cmd(CMD_PIXEL, ax, ay, nearby(ax), nearby(ay),
                                  rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                                  $urandom_range(2047), $urandom_range(255));
    if (sel < 57) return make_cmd(CMD_LINE, ax, ay, nearby(ax), nearby(ay), 0, 0, 0,
                                  $urandom_range(255));
    if (sel < 65) return make_cmd(CMD_OUTLINE, ax, ay, nearby(ax), nearby(ay), 0, 0, 0,
                                  $urandom_range(255));
    if (sel < 73) return make_cmd(CMD_BOX, ax, ay, nearby(ax), nearby(ay), 0, 0, 0,
                                  $urandom_range(255));
    if (sel < 83) return make_cmd(CMD_CIRCLE, ax, ay, 0, 0, 0, 0, r, $urandom_range(255));
    if (sel < 98) begin
      // some triangles share rows to hit the flat and flat-edge paths
      if ($urandom_range(7) == 0)
        return make_cmd(CMD_TRI, ax, ay, nearby(ax), ay, nearby(ax),
                        $urandom_range(1) ? ay : nearby(ay), 0, $urandom_range(255));
      return make_cmd(CMD_TRI, ax, ay, nearby(ax), nearby(ay), nearby(ax), nearby(ay), 0,
                      $urandom_range(255));
    end
    return make_cmd(CMD_SPARE, rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                    rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                    rand_signed(-2048, 2047), rand_signed(-2048, 2047),
                    $urandom_range(2047), $urandom_range(255));
  endfunction

  // ---------------- tests ----------------
  task automatic test_primitives();
    send_command(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 8'hff));
    send_command(make_cmd(CMD_PIXEL, CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 0, 0, 0, 0, 0, 1));
    send_command(make_cmd(CMD_PIXEL, -2048, -2048, 0, 0, 0, 0, 0, 2));
    send_command(make_cmd(CMD_PIXEL, 2047, 2047, 0, 0, 0, 0, 0, 3));
    send_command(make_cmd(CMD_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 8'h5a));
    send_command(make_cmd(CMD_LINE, 40, 20, 40, 20, 0, 0, 0, 8'h11));
    send_command(make_cmd(CMD_LINE, 500, 10, 100, 200, 0, 0, 0, 8'h22));
    send_command(make_cmd(CMD_OUTLINE, 520, 250, -5, 100, 0, 0, 0, 8'h33));
    send_command(make_cmd(CMD_BOX, 60, 40, 10, 5, 0, 0, 0, 8'h44));
    send_command(make_cmd(CMD_BOX, -2048, -5, 10, 3, 0, 0, 0, 8'h45));
    send_command(make_cmd(CMD_CIRCLE, 300, 150, 0, 0, 0, 0, 0, 8'h55));
    send_command(make_cmd(CMD_CIRCLE, 256, 128, 0, 0, 0, 0, 2047, 8'h66));
    send_command(make_cmd(CMD_CIRCLE, 200, 100, 0, 0, 0, 0, 30, 8'h67));
    send_command(make_cmd(CMD_TRI, 100, 100, 130, 100, 90, 100, 0, 8'h77));
    send_command(make_cmd(CMD_TRI, 200, 10, 150, 60, 260, 40, 0, 8'h88));
    send_command(make_cmd(CMD_TRI, 10, -2048, 12, 2047, 20, 0, 0, 8'h99));
    send_command(make_cmd(CMD_TRI, 300, 50, 340, 50, 320, 90, 0, 8'haa));
    send_command(make_cmd(CMD_SPARE, 5, 5, 6, 6, 7, 7, 7, 8'hbb));
    send_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, CANVAS_WIDTH - 1, CANVAS_HEIGHT - 1, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, 300, 150, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_READ, 0, CANVAS_HEIGHT, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_command(random_command());
  endtask

  task automatic test_drained_read();
    // hold off until every transaction has returned, then read back
    cmd_valid <= 1'b0;
    while (expected_readback.size() != 0) @(negedge clk);
    send_command(random_read());
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    for (int i = 0; i < CANVAS_SIZE; i++) begin
      shadow_canvas[i] = '0;
      painted[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_primitives();
    test_random_traffic(320, 0, 0);
    test_drained_read();
    test_random_traffic(320, 78, 0);
    test_random_traffic(320, 0, 78);
    test_drained_read();
    test_random_traffic(320, 30, 30);
    cmd_valid <= 1'b0;
    while (expected_readback.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("primitive_raster_engine_tb: PASS");
    else $display("primitive_raster_engine_tb: FAIL");
    $finish;
  end

  initial begin
    #(12 * 20_000_000);
    $display("primitive_raster_engine_tb: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
sv/pre_pkg.sv
sv/pre_ctrl.sv
sv/pre_dp.sv
sv/primitive_raster_engine.sv
tb/primitive_raster_engine_tb.sv
